// ===== rtl/sdf_pkg.sv =====
// Shared constants for the SLIP message deframer.
package sdf_pkg;

    localparam int BUFFER_BYTES_DEF = 128;
    localparam int HDR_BYTES = 2;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam int VAL_CNT_W = 6;

endpackage

// ===== rtl/slip_message_deframer.sv =====
// Top level of the SLIP message deframer with its packet sequencer.
//
// The input channel takes one received serial byte per transaction on
// i_valid / o_stall. SLIP framing is removed and unstuffed bytes are
// written into the packet store, one byte per cycle while idle. When END
// closes a packet of at least two bytes, the block stalls its input and
// walks the store through its single read port: the command and target id
// are fetched first, then each data value is read as low byte, high byte
// and output load, and the low byte read of the first value is issued
// in the last header state. A packet without values gives one result
// with value_valid low. Results leave on o_valid / i_stall through an
// output register; while the receiver stalls, the sequencer holds its
// fetched byte and waits. Input is accepted again once the last result
// of the run is loaded. Reset clears the byte count, the escape and
// overflow flags, the sequencer and the output valid; the store contents
// are left as they are and only entries written in the current packet
// are read.
module slip_message_deframer #(
    parameter int BUFFER_BYTES = sdf_pkg::BUFFER_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_command,
    output logic [7:0]         o_target_id,
    output logic signed [15:0] o_value,
    output logic [5:0]         o_value_index,
    output logic [5:0]         o_value_count,
    output logic               o_value_valid,
    output logic               o_truncated,
    output logic               o_last
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int VW = sdf_pkg::VAL_CNT_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RD_CMD = 7'b0000010,
        S_RD_JID = 7'b0000100,
        S_HDR    = 7'b0001000,
        S_RD_LO  = 7'b0010000,
        S_RD_HI  = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_esc, n_esc;
    logic            r_ovf, n_ovf;
    logic [AW-1:0]   r_raddr, n_raddr;
    logic [VW-1:0]   r_nval, n_nval;
    logic [VW-1:0]   r_k, n_k;
    logic            r_trunc, n_trunc;
    logic [7:0]      r_cmd, n_cmd;
    logic [7:0]      r_jid, n_jid;
    logic [7:0]      r_lo, n_lo;

    logic            r_o_valid, n_o_valid;
    logic [7:0]      r_o_cmd, n_o_cmd;
    logic [7:0]      r_o_jid, n_o_jid;
    logic [15:0]     r_o_value, n_o_value;
    logic [VW-1:0]   r_o_index, n_o_index;
    logic [VW-1:0]   r_o_count, n_o_count;
    logic            r_o_vvalid, n_o_vvalid;
    logic            r_o_trunc, n_o_trunc;
    logic            r_o_last, n_o_last;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    logic            rd_en;
    logic [7:0]      rd_data;
    logic [7:0]      esc_byte;
    logic [CW-1:0]   pairs;
    logic            out_free;
    logic            last_now;

    sdf_ram #(
        .DEPTH  (BUFFER_BYTES),
        .ADDR_W (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_raddr),
        .o_rd_data (rd_data)
    );

    assign out_free = !r_o_valid || !i_stall;
    assign last_now = (r_nval == '0) || (r_k == (r_nval - VW'(1)));
    assign pairs    = (r_count - CW'(sdf_pkg::HDR_BYTES)) >> 1;

    always_comb begin
        if (i_rx_byte == sdf_pkg::SLIP_ESC_END) begin
            esc_byte = sdf_pkg::SLIP_END;
        end else if (i_rx_byte == sdf_pkg::SLIP_ESC_ESC) begin
            esc_byte = sdf_pkg::SLIP_ESC;
        end else begin
            esc_byte = i_rx_byte;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_esc      = r_esc;
        n_ovf      = r_ovf;
        n_raddr    = r_raddr;
        n_nval     = r_nval;
        n_k        = r_k;
        n_trunc    = r_trunc;
        n_cmd      = r_cmd;
        n_jid      = r_jid;
        n_lo       = r_lo;
        n_o_valid  = r_o_valid && i_stall;
        n_o_cmd    = r_o_cmd;
        n_o_jid    = r_o_jid;
        n_o_value  = r_o_value;
        n_o_index  = r_o_index;
        n_o_count  = r_o_count;
        n_o_vvalid = r_o_vvalid;
        n_o_trunc  = r_o_trunc;
        n_o_last   = r_o_last;
        wr_en      = 1'b0;
        wr_addr    = r_count[AW-1:0];
        wr_data    = i_rx_byte;
        rd_en      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (r_esc) begin
                        n_esc   = 1'b0;
                        wr_data = esc_byte;
                        if (r_count < CW'(BUFFER_BYTES)) begin
                            wr_en   = 1'b1;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (i_rx_byte == sdf_pkg::SLIP_END) begin
                        if (r_count != '0) begin
                            if (r_count >= CW'(sdf_pkg::HDR_BYTES)) begin
                                n_nval  = VW'(pairs);
                                n_trunc = r_ovf;
                                n_k     = '0;
                                n_raddr = '0;
                                n_state = S_RD_CMD;
                            end
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                    end else if (i_rx_byte == sdf_pkg::SLIP_ESC) begin
                        n_esc = 1'b1;
                    end else if (r_count < CW'(BUFFER_BYTES)) begin
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            S_RD_CMD: begin
                rd_en   = 1'b1;
                n_raddr = r_raddr + AW'(1);
                n_state = S_RD_JID;
            end
            S_RD_JID: begin
                rd_en   = 1'b1;
                n_raddr = r_raddr + AW'(1);
                n_cmd   = rd_data;
                n_state = S_HDR;
            end
            S_HDR: begin
                n_jid = rd_data;
                if (r_nval != '0) begin
                    rd_en   = 1'b1;
                    n_raddr = r_raddr + AW'(1);
                    n_state = S_RD_HI;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_RD_LO: begin
                rd_en   = 1'b1;
                n_raddr = r_raddr + AW'(1);
                n_state = S_RD_HI;
            end
            S_RD_HI: begin
                rd_en   = 1'b1;
                n_raddr = r_raddr + AW'(1);
                n_lo    = rd_data;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_cmd    = r_cmd;
                    n_o_jid    = r_jid;
                    n_o_value  = (r_nval == '0) ? 16'd0 : {rd_data, r_lo};
                    n_o_index  = r_k;
                    n_o_count  = r_nval;
                    n_o_vvalid = (r_nval != '0);
                    n_o_trunc  = r_trunc;
                    n_o_last   = last_now;
                    if (last_now) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + VW'(1);
                        n_state = S_RD_LO;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_esc     <= 1'b0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_esc     <= n_esc;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr    <= n_raddr;
        r_nval     <= n_nval;
        r_k        <= n_k;
        r_trunc    <= n_trunc;
        r_cmd      <= n_cmd;
        r_jid      <= n_jid;
        r_lo       <= n_lo;
        r_o_cmd    <= n_o_cmd;
        r_o_jid    <= n_o_jid;
        r_o_value  <= n_o_value;
        r_o_index  <= n_o_index;
        r_o_count  <= n_o_count;
        r_o_vvalid <= n_o_vvalid;
        r_o_trunc  <= n_o_trunc;
        r_o_last   <= n_o_last;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_command     = r_o_cmd;
    assign o_target_id   = r_o_jid;
    assign o_value       = $signed(r_o_value);
    assign o_value_index = r_o_index;
    assign o_value_count = r_o_count;
    assign o_value_valid = r_o_vvalid;
    assign o_truncated   = r_o_trunc;
    assign o_last        = r_o_last;

endmodule

// ===== rtl/sdf_ram.sv =====
// Packet store: one write port, one read port with registered read data.
module sdf_ram #(
    parameter int DEPTH  = sdf_pkg::BUFFER_BYTES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
